// ===== hw/rtl/dss_pkg.sv =====
package dss_pkg;

    localparam int DEF_MAX_PRIME  = 31;
    localparam int DEF_HYPERSLOTS = 5;
    localparam int DEF_SLOT_US    = 250;

    localparam int OFFSET_W = 18;
    localparam int SLOT_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_PRIME_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTACT_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_MODE   = 2'd2;

    localparam logic [1:0] PHASE_DISCRETE = 2'd2;
    localparam logic [4:0] PRIME_RESET    = 5'd3;
    localparam int         PRIME_MIN      = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WALK
    } t_state;

    typedef enum logic [1:0] {
        SLOT_IDLE,
        SLOT_BEACON,
        SLOT_LISTEN
    } t_slot;

    typedef struct packed {
        logic contact_any;
        logic exact;
    } t_walk_mode;

    typedef struct packed {
        logic done;
        logic found;
    } t_walk_res;

endpackage

// ===== hw/rtl/dss_divider.sv =====
module dss_divider #(
    parameter int SLOT_US = dss_pkg::DEF_SLOT_US
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [dss_pkg::OFFSET_W-1:0]          i_dividend,
    output logic                                  o_done,
    output logic [dss_pkg::OFFSET_W-1:0]          o_quotient,
    output logic [((SLOT_US > 1) ? $clog2(SLOT_US) : 1)-1:0] o_remainder
);
    import dss_pkg::*;

    localparam int RW = (SLOT_US > 1) ? $clog2(SLOT_US) : 1;
    localparam int SH = OFFSET_W + $clog2(SLOT_US);
    localparam int PW = SH + OFFSET_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SH) + 64'(SLOT_US) - 64'd1) / 64'(SLOT_US);
    localparam logic [PW-1:0]       RECIP   = RECIP_FULL[PW-1:0];
    localparam logic [OFFSET_W-1:0] DIVISOR = OFFSET_W'(SLOT_US);

    logic                r_mul;
    logic                r_sub;
    logic                r_done;
    logic [OFFSET_W-1:0] r_x;
    logic [OFFSET_W-1:0] r_q;
    logic [RW-1:0]       r_r;

    logic [PW-1:0]       prod;
    logic [OFFSET_W-1:0] q_times_d;
    logic [OFFSET_W-1:0] rem_full;

    // quotient by reciprocal multiply, exact over the whole dividend range
    assign prod      = PW'(r_x) * RECIP;
    assign q_times_d = r_q * DIVISOR;
    assign rem_full  = r_x - q_times_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_sub  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_mul  <= i_start;
            r_sub  <= r_mul;
            r_done <= r_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) r_x <= i_dividend;
        if (r_mul)   r_q <= prod[SH +: OFFSET_W];
        if (r_sub)   r_r <= rem_full[RW-1:0];
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_r;

endmodule

// ===== hw/rtl/dss_slot_walker.sv =====
module dss_slot_walker #(
    parameter int MAX_PRIME  = dss_pkg::DEF_MAX_PRIME,
    parameter int HYPERSLOTS = dss_pkg::DEF_HYPERSLOTS
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_start,
    input  logic [dss_pkg::OFFSET_W-1:0]                         i_shift,
    input  logic [$clog2(MAX_PRIME + 1)-1:0]                     i_p,
    input  logic [$clog2(MAX_PRIME * MAX_PRIME + 1)-1:0]         i_hs,
    input  logic [$clog2(HYPERSLOTS * MAX_PRIME * MAX_PRIME + 1)-1:0] i_span,
    input  dss_pkg::t_walk_mode                                  i_mode,
    output dss_pkg::t_walk_res                                   o_res,
    output logic [$clog2(HYPERSLOTS * MAX_PRIME * MAX_PRIME + 1)-1:0] o_slot
);
    import dss_pkg::*;

    localparam int P_W    = $clog2(MAX_PRIME + 1);
    localparam int HS_W   = $clog2(MAX_PRIME * MAX_PRIME + 1);
    localparam int SPAN_W = $clog2(HYPERSLOTS * MAX_PRIME * MAX_PRIME + 1);

    function automatic t_slot kind(input logic [HS_W-1:0] mhs, input logic [P_W-1:0] mp,
                                   input logic [P_W:0] thr);
        t_slot k;
        if (32'(mhs) < 32'(thr)) k = SLOT_BEACON;
        else if (mp == '0)       k = SLOT_LISTEN;
        else                     k = SLOT_IDLE;
        return k;
    endfunction

    logic              r_run;
    logic              r_done;
    logic              r_found;
    logic              r_act;
    logic [SPAN_W-1:0] r_a;
    logic [SPAN_W-1:0] r_slot;
    logic [P_W-1:0]    r_am_p;
    logic [HS_W-1:0]   r_am_hs;
    logic [P_W-1:0]    r_bm_p;
    logic [HS_W-1:0]   r_bm_hs;

    logic [P_W:0]      thr;
    logic [P_W-1:0]    p_last;
    logic [HS_W-1:0]   hs_last;
    logic [P_W-1:0]    b_p;
    logic [HS_W-1:0]   b_hs;
    logic [P_W-1:0]    a1_p;
    logic [HS_W-1:0]   a1_hs;
    logic [P_W-1:0]    b1n_p;
    logic [HS_W-1:0]   b1n_hs;
    logic [P_W-1:0]    bm1_p;
    logic [HS_W-1:0]   bm1_hs;
    logic              at_shift;
    logic              eval;
    logic              last;
    logic              hit;
    t_slot             sa;
    t_slot             sb;
    t_slot             sa_next;
    t_slot             sb_prev;

    assign thr     = ({1'b0, i_p} + 1'b1) >> 1;
    assign p_last  = i_p - 1'b1;
    assign hs_last = i_hs - 1'b1;

    assign b_p  = r_act ? r_bm_p  : '0;
    assign b_hs = r_act ? r_bm_hs : '0;

    assign a1_p   = (r_am_p  == p_last)  ? '0 : r_am_p  + 1'b1;
    assign a1_hs  = (r_am_hs == hs_last) ? '0 : r_am_hs + 1'b1;
    assign b1n_p  = (b_p  == p_last)  ? '0 : b_p  + 1'b1;
    assign b1n_hs = (b_hs == hs_last) ? '0 : b_hs + 1'b1;
    assign bm1_p  = (b_p  == '0) ? p_last  : b_p  - 1'b1;
    assign bm1_hs = (b_hs == '0) ? hs_last : b_hs - 1'b1;

    assign at_shift = (32'(r_a) == 32'(i_shift));
    assign eval     = r_act || at_shift;
    assign last     = (32'(r_a) == 32'(i_span) - 32'd1);

    assign sa      = kind(r_am_hs, r_am_p, thr);
    assign sb      = kind(b_hs, b_p, thr);
    assign sa_next = kind(a1_hs, a1_p, thr);
    assign sb_prev = kind(bm1_hs, bm1_p, thr);

    always_comb begin
        hit = 1'b0;
        if (!i_mode.contact_any) begin
            if ((sa == SLOT_BEACON && sb == SLOT_LISTEN) ||
                (sa == SLOT_LISTEN && sb == SLOT_BEACON)) begin
                if (i_mode.exact)          hit = 1'b1;
                else if (sa == SLOT_BEACON) hit = (sa_next == SLOT_BEACON);
                else                       hit = (sb_prev == SLOT_BEACON);
            end
        end else if (sa != SLOT_IDLE && sb != SLOT_IDLE) begin
            if (i_mode.exact) hit = 1'b1;
            else              hit = (sa_next != SLOT_IDLE) || (sb_prev != SLOT_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
            r_act   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run   <= 1'b1;
                r_act   <= 1'b0;
                r_found <= 1'b0;
            end else if (r_run) begin
                if (eval && hit) begin
                    r_run   <= 1'b0;
                    r_done  <= 1'b1;
                    r_found <= 1'b1;
                end else if (last) begin
                    r_run   <= 1'b0;
                    r_done  <= 1'b1;
                    r_found <= 1'b0;
                end
                if (eval) r_act <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a     <= '0;
            r_am_p  <= '0;
            r_am_hs <= '0;
        end else if (r_run) begin
            r_a     <= r_a + 1'b1;
            r_am_p  <= a1_p;
            r_am_hs <= a1_hs;
            r_bm_p  <= b1n_p;
            r_bm_hs <= b1n_hs;
            if (eval && hit) r_slot <= r_a;
            else if (last)   r_slot <= '0;
        end
    end

    assign o_res.done  = r_done;
    assign o_res.found = r_found;
    assign o_slot      = r_slot;

endmodule

// ===== hw/rtl/discovery_slot_search.sv =====
// Neighbor discovery slot search for a prime-period duty-cycle schedule.
// Configuration: write prime_period (index 0), contact_mode (index 1) and
// phase_mode (index 2) on the cfg channel; a transfer completes when
// i_cfg_valid and o_cfg_ready are high. o_cfg_ready is always high.
// Write only while busy is low and no result is pending.
// Command: drive i_phase_offset_us and raise start; the command is taken
// at a clock edge with start high and busy low. busy then stays high
// until the cycle after the result strobe.
// Search: the offset is split into slot shift and in-slot phase by a
// registered reciprocal multiply, then the slot walker visits one node A
// slot per cycle from slot 0, up to HYPERSLOTS*p*p slots (4805 at p = 31),
// stopping at the first contact.
// Result: o_done is high for exactly one cycle with o_contact_slot and
// o_not_found valid; the receiver cannot stall and must take it then.
// Reset: synchronous active-low i_rst_n aborts any search and restores
// prime_period 3, contact_mode 0, phase_mode 0.
module discovery_slot_search #(
    parameter int MAX_PRIME  = dss_pkg::DEF_MAX_PRIME,
    parameter int HYPERSLOTS = dss_pkg::DEF_HYPERSLOTS,
    parameter int SLOT_US    = dss_pkg::DEF_SLOT_US
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [dss_pkg::OFFSET_W-1:0]       i_phase_offset_us,
    output logic                               o_done,
    output logic [dss_pkg::SLOT_W-1:0]         o_contact_slot,
    output logic                               o_not_found,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dss_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dss_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import dss_pkg::*;

    localparam int P_W    = $clog2(MAX_PRIME + 1);
    localparam int HS_W   = $clog2(MAX_PRIME * MAX_PRIME + 1);
    localparam int SPAN_W = $clog2(HYPERSLOTS * MAX_PRIME * MAX_PRIME + 1);
    localparam int RW     = (SLOT_US > 1) ? $clog2(SLOT_US) : 1;

    t_state            r_state;
    t_state            n_state;
    logic [4:0]        r_prime;
    logic              r_cmode;
    logic [1:0]        r_pmode;
    logic [P_W-1:0]    r_p;
    logic [HS_W-1:0]   r_hs;
    logic [SPAN_W-1:0] r_span;

    logic [31:0]         eff_p;
    logic                accept;
    logic                div_done;
    logic [OFFSET_W-1:0] shift;
    logic [RW-1:0]       slot_phase;
    t_walk_mode          mode;
    t_walk_res           res;
    logic [SPAN_W-1:0]   w_slot;
    logic [31:0]         slot_ext;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (32'(r_prime) < 32'(PRIME_MIN))     eff_p = 32'(PRIME_MIN);
        else if (32'(r_prime) > 32'(MAX_PRIME)) eff_p = 32'(MAX_PRIME);
        else                                    eff_p = 32'(r_prime);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime <= PRIME_RESET;
            r_cmode <= 1'b0;
            r_pmode <= 2'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PRIME_PERIOD: r_prime <= i_cfg_data;
                CFG_CONTACT_MODE: r_cmode <= i_cfg_data[0];
                CFG_PHASE_MODE:   r_pmode <= i_cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p  <= P_W'(eff_p);
            r_hs <= HS_W'(eff_p * eff_p);
        end
        r_span <= SPAN_W'(32'(HYPERSLOTS) * 32'(r_hs));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        busy    = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) n_state = ST_DIV;
            end
            ST_DIV:  if (div_done) n_state = ST_WALK;
            ST_WALK: if (res.done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    dss_divider #(
        .SLOT_US(SLOT_US)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (i_phase_offset_us),
        .o_done     (div_done),
        .o_quotient (shift),
        .o_remainder(slot_phase)
    );

    assign mode.contact_any = r_cmode;
    assign mode.exact       = (slot_phase == '0) || (r_pmode == PHASE_DISCRETE);

    dss_slot_walker #(
        .MAX_PRIME (MAX_PRIME),
        .HYPERSLOTS(HYPERSLOTS)
    ) u_walk (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_done),
        .i_shift(shift),
        .i_p    (r_p),
        .i_hs   (r_hs),
        .i_span (r_span),
        .i_mode (mode),
        .o_res  (res),
        .o_slot (w_slot)
    );

    assign slot_ext       = 32'(w_slot);
    assign o_done         = res.done;
    assign o_contact_slot = slot_ext[SLOT_W-1:0];
    assign o_not_found    = !res.found;

endmodule

// ===== dv/discovery_slot_search_checker.sv =====
`timescale 1ns / 1ps

module discovery_slot_search_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [dss_pkg::OFFSET_W-1:0]   i_offset,
    input  logic                           i_done,
    input  logic [dss_pkg::SLOT_W-1:0]     i_contact_slot,
    input  logic                           i_not_found,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [dss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_mismatches,
    output int                             o_pending
);
    import dss_pkg::*;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [SLOT_W-1:0]   slot;
        logic                miss;
    } t_contact;

    t_contact   contact_q[$];
    logic [4:0] prime_reg;
    logic       contact_any;
    logic [1:0] phase_reg;
    int         errors = 0;

    function automatic t_slot classify(int unsigned s, int unsigned p);
        if ((s % (p * p)) < ((p + 1) / 2)) return SLOT_BEACON;
        if ((s % p) == 0) return SLOT_LISTEN;
        return SLOT_IDLE;
    endfunction

    function automatic t_contact first_contact(logic [OFFSET_W-1:0] offset);
        int unsigned p, span, shift, b;
        bit          exact, hit;
        t_slot       sa, sb;
        t_contact    res;
        p = prime_reg;
        if (p < PRIME_MIN) p = PRIME_MIN;
        if (p > DEF_MAX_PRIME) p = DEF_MAX_PRIME;
        span  = DEF_HYPERSLOTS * p * p;
        shift = offset / DEF_SLOT_US;
        exact = ((offset % DEF_SLOT_US) == 0) || (phase_reg == PHASE_DISCRETE);
        res.offset = offset;
        res.slot   = '0;
        res.miss   = 1'b1;
        for (int unsigned a = shift; a < span; a++) begin
            b = a - shift;
            if (b == 0) b = p * p;
            sa  = classify(a, p);
            sb  = classify(b, p);
            hit = 1'b0;
            if (!contact_any) begin
                if ((sa == SLOT_BEACON && sb == SLOT_LISTEN) ||
                    (sa == SLOT_LISTEN && sb == SLOT_BEACON)) begin
                    if (exact) hit = 1'b1;
                    else if (sa == SLOT_BEACON) hit = (classify(a + 1, p) == SLOT_BEACON);
                    else hit = (classify(b - 1, p) == SLOT_BEACON);
                end
            end else if (sa != SLOT_IDLE && sb != SLOT_IDLE) begin
                hit = exact || (classify(a + 1, p) != SLOT_IDLE) ||
                      (classify(b - 1, p) != SLOT_IDLE);
            end
            if (hit) begin
                res.slot = SLOT_W'(a);
                res.miss = 1'b0;
                return res;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_contact want;
        if (!i_rst_n) begin
            prime_reg   <= PRIME_RESET;
            contact_any <= 1'b0;
            phase_reg   <= '0;
            contact_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PRIME_PERIOD: prime_reg   <= i_cfg_data;
                    CFG_CONTACT_MODE: contact_any <= i_cfg_data[0];
                    CFG_PHASE_MODE:   phase_reg   <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_done) begin
                if (contact_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("[%0t] unexpected result: slot %0d not_found %0b",
                                 $realtime, i_contact_slot, i_not_found);
                end else begin
                    want = contact_q.pop_front();
                    if (want.slot !== i_contact_slot || want.miss !== i_not_found) begin
                        errors++;
                        if (errors <= 10)
                            $display(
                                "[%0t] offset %0d: expected slot %0d nf %0b, got slot %0d nf %0b",
                                $realtime, want.offset, want.slot, want.miss,
                                i_contact_slot, i_not_found);
                    end
                end
            end
            if (i_start && !i_busy) contact_q.push_back(first_contact(i_offset));
        end
        o_mismatches <= errors;
        o_pending    <= contact_q.size();
    end

endmodule

// ===== dv/discovery_slot_search_tb.sv =====
`timescale 1ns / 1ps

module discovery_slot_search_tb;
    import dss_pkg::*;

    localparam int         WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] PHASE_NONE     = 2'd0;
    localparam logic [1:0] PHASE_CONT     = 2'd1;
    localparam logic [1:0] PHASE_SPARE    = 2'd3;
    localparam logic       CONTACT_BL     = 1'b0;
    localparam logic       CONTACT_ANY    = 1'b1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [OFFSET_W-1:0]   i_phase_offset_us = '0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  busy, o_done, o_not_found, o_cfg_ready;
    logic [SLOT_W-1:0]     o_contact_slot;

    int          mismatches, pending;
    int          idle_cycles = 0;
    int          offsets_sent = 0;
    int          settings_run = 1;
    int unsigned gap_max = 12;
    logic [4:0]  prime_setting = PRIME_RESET;

    discovery_slot_search uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_phase_offset_us (i_phase_offset_us),
        .o_done            (o_done),
        .o_contact_slot    (o_contact_slot),
        .o_not_found       (o_not_found),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    discovery_slot_search_checker contact_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_offset       (i_phase_offset_us),
        .i_done         (o_done),
        .i_contact_slot (o_contact_slot),
        .i_not_found    (o_not_found),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_offset(input logic [OFFSET_W-1:0] offset);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0) begin
            if (start) start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start             <= 1'b1;
        i_phase_offset_us <= offset;
        do @(posedge i_clk); while (busy);
        offsets_sent++;
    endtask

    // hold off until every search has reported
    task automatic drain();
        if (start) start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
    endtask

    task automatic write_config(input logic [4:0] prime, input logic rule,
                                input logic [1:0] phase);
        logic [CFG_IDX_W-1:0]  regs [3];
        logic [CFG_DATA_W-1:0] vals [3];
        regs[0] = CFG_PRIME_PERIOD;
        regs[1] = CFG_CONTACT_MODE;
        regs[2] = CFG_PHASE_MODE;
        vals[0] = prime;
        vals[1] = CFG_DATA_W'(rule);
        vals[2] = CFG_DATA_W'(phase);
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid   <= 1'b0;
        prime_setting = prime;
        settings_run++;
    endtask

    // mostly offsets that land inside the searched span
    function automatic logic [OFFSET_W-1:0] random_offset();
        int unsigned p, reach;
        p = prime_setting;
        if (p < PRIME_MIN) p = PRIME_MIN;
        if (p > DEF_MAX_PRIME) p = DEF_MAX_PRIME;
        reach = DEF_HYPERSLOTS * p * p * DEF_SLOT_US;
        if (reach > 2 ** OFFSET_W) reach = 2 ** OFFSET_W;
        case ($urandom_range(0, 9))
            0:       return OFFSET_W'($urandom_range(0, 2 ** OFFSET_W - 1));
            1, 2, 3: return OFFSET_W'(($urandom_range(0, reach - 1) / DEF_SLOT_US) * DEF_SLOT_US);
            default: return OFFSET_W'($urandom_range(0, reach - 1));
        endcase
    endfunction

    initial begin
        int         reset_offsets [11];
        logic [4:0] prime;
        reset_offsets = '{0, 1, 249, 250, 251, 500, 2250, 11249, 11250, 240249, 262143};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (reset_offsets[i]) send_offset(OFFSET_W'(reset_offsets[i]));
        drain();
        write_config(5'd0, CONTACT_ANY, PHASE_SPARE);
        send_offset(OFFSET_W'(0));
        send_offset(OFFSET_W'(125));
        send_offset(OFFSET_W'(250));
        drain();
        write_config(5'd9, CONTACT_BL, PHASE_DISCRETE);
        send_offset(OFFSET_W'(251));
        send_offset(OFFSET_W'(1249));
        drain();
        write_config(5'd31, CONTACT_ANY, PHASE_CONT);
        send_offset(OFFSET_W'(0));
        send_offset(OFFSET_W'(262143));
        send_offset(OFFSET_W'(60125));

        for (int k = 0; k < 8; k++) begin
            case (k)
                0:       prime = 5'd31;
                1:       prime = 5'd0;
                2:       prime = 5'd3;
                4:       prime = 5'($urandom_range(0, 31));
                5:       prime = 5'($urandom_range(4, 16));
                6:       prime = 5'd1;
                default: prime = 5'($urandom_range(0, 13));
            endcase
            drain();
            write_config(prime, (k / 4) ? CONTACT_ANY : CONTACT_BL,
                         (k % 4 == 0) ? PHASE_NONE : (k % 4 == 1) ? PHASE_CONT :
                         (k % 4 == 2) ? PHASE_DISCRETE : PHASE_SPARE);
            gap_max = (k == 2 || k == 5) ? 0 : 12;
            repeat (13) begin
                send_offset(random_offset());
                if ($urandom_range(0, 19) == 0) drain();
            end
        end

        drain();
        repeat (30) @(posedge i_clk);
        $display("Searched %0d phase offsets under %0d register settings:", offsets_sent,
                 settings_run);
        $display("periods 0 to 31, both contact rules, all four phase modes.");
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
